// ===== sv/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared sizes, command codes and word types of the SELL-C-sigma SpMV block.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int unsigned LANES        = 8;
  localparam int unsigned VECTOR_DEPTH = 1024;

  localparam int unsigned LANE_W  = $clog2(LANES);
  localparam int unsigned VADDR_W = $clog2(VECTOR_DEPTH);
  localparam int unsigned CNT_W   = $clog2(LANES + 1);

  typedef enum logic [1:0] {
    CMD_STORE = 2'd0,
    CMD_ROW   = 2'd1,
    CMD_ELEM  = 2'd2,
    CMD_CLOSE = 2'd3
  } ssp_cmd_e;

  typedef struct packed {
    ssp_cmd_e           command;
    logic [15:0]        index;
    logic [15:0]        row_number;
    logic signed [31:0] value;
    logic [15:0]        column;
  } ssp_in_t;

  typedef struct packed {
    logic [15:0]        result_row;
    logic signed [63:0] sum;
    logic               last;
  } ssp_out_t;

  // Word handed from the multiply stage to the accumulate stage.
  typedef struct packed {
    logic               valid;
    ssp_cmd_e           cmd;
    logic [LANE_W-1:0]  lane;
    logic               ok;
    logic [15:0]        row;
    logic signed [63:0] prod;
  } ssp_prod_t;

endpackage

// ===== sv/ssp_ram.sv =====
// ----------------------------------------------------------------------------
// ssp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ssp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/ssp_front.sv =====
// ----------------------------------------------------------------------------
// ssp_front
// Input decode, lane pointer, vector store and the multiply stage.
// ----------------------------------------------------------------------------
module ssp_front import ssp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  ssp_in_t   in_word_i,
  input  logic      en_i,
  output ssp_prod_t prod_o
);

  logic              accept;
  logic [LANE_W-1:0] lane_ptr_q, lane_ptr_d;
  logic              vec_we;
  logic [31:0]       vec_rdata;

  logic              s1_valid_q;
  ssp_cmd_e          s1_cmd_q;
  logic [LANE_W-1:0] s1_lane_q;
  logic              s1_ok_q;
  logic [15:0]       s1_row_q;
  logic signed [31:0] s1_val_q;

  logic signed [31:0] x_sel;
  logic signed [63:0] prod_full;
  ssp_prod_t          s2_q;

  assign accept = in_valid_i && en_i;

  assign vec_we = accept && (in_word_i.command == CMD_STORE) &&
                  (32'(in_word_i.index) < 32'(VECTOR_DEPTH));

  ssp_ram #(
    .WIDTH (32),
    .DEPTH (VECTOR_DEPTH)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (in_word_i.index[VADDR_W-1:0]),
    .wdata_i (in_word_i.value),
    .re_i    (accept),
    .raddr_i (in_word_i.column[VADDR_W-1:0]),
    .rdata_o (vec_rdata)
  );

  always_comb begin
    lane_ptr_d = lane_ptr_q;
    if (accept) begin
      case (in_word_i.command)
        CMD_ELEM: begin
          lane_ptr_d = (lane_ptr_q == LANE_W'(LANES - 1)) ? '0 : lane_ptr_q + 1'b1;
        end
        CMD_CLOSE: lane_ptr_d = '0;
        default:   lane_ptr_d = lane_ptr_q;
      endcase
    end
  end

  // Stage one: the vector entry is being read; the lane and the range check
  // of the column (or of the lane number for a row command) ride along.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_cmd_q <= in_word_i.command;
      s1_row_q <= in_word_i.row_number;
      s1_val_q <= in_word_i.value;
      if (in_word_i.command == CMD_ROW) begin
        s1_lane_q <= in_word_i.index[LANE_W-1:0];
        s1_ok_q   <= 32'(in_word_i.index) < 32'(LANES);
      end else begin
        s1_lane_q <= lane_ptr_q;
        s1_ok_q   <= 32'(in_word_i.column) < 32'(VECTOR_DEPTH);
      end
    end
  end

  assign x_sel     = s1_ok_q ? $signed(vec_rdata) : 32'sd0;
  assign prod_full = s1_val_q * x_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_ptr_q <= '0;
      s1_valid_q <= 1'b0;
      s2_q       <= '0;
    end else begin
      lane_ptr_q <= lane_ptr_d;
      if (en_i) begin
        s1_valid_q <= in_valid_i;
        s2_q.valid <= s1_valid_q;
        s2_q.cmd   <= s1_cmd_q;
        s2_q.lane  <= s1_lane_q;
        s2_q.ok    <= s1_ok_q;
        s2_q.row   <= s1_row_q;
        s2_q.prod  <= prod_full;
      end
    end
  end

  assign prod_o = s2_q;

  ap_close_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_word_i.command == CMD_CLOSE)) |=> (lane_ptr_q == '0))
    else $error("lane pointer not rewound after a close");

endmodule

// ===== sv/ssp_accum.sv =====
// ----------------------------------------------------------------------------
// ssp_accum
// Per-lane saturating accumulators, lane rows and the result emitter.
// ----------------------------------------------------------------------------
module ssp_accum import ssp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ssp_prod_t prod_i,
  output logic      en_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ssp_out_t  out_word_o
);

  logic signed [63:0] sums_q [LANES];
  logic [15:0]        rows_q [LANES];
  logic signed [63:0] sh_sum_q [LANES];
  logic [15:0]        sh_row_q [LANES];
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               out_take;
  logic               emit_free;
  logic               retire;
  logic               close_retire;
  logic signed [63:0] acc_a;
  logic signed [63:0] acc_s;
  logic signed [63:0] acc_sat;

  assign out_valid_o = (cnt_q != '0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign emit_free   = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && out_take);

  // A close may only retire once the previous chunk has left the emitter.
  assign en_o = !(prod_i.valid && (prod_i.cmd == CMD_CLOSE) && !emit_free);

  assign retire       = en_o && prod_i.valid;
  assign close_retire = retire && (prod_i.cmd == CMD_CLOSE);

  assign acc_a = sums_q[prod_i.lane];
  assign acc_s = acc_a + prod_i.prod;

  // Overflow only when both operands share a sign that the sum lost.
  always_comb begin
    acc_sat = acc_s;
    if ((acc_a[63] == prod_i.prod[63]) && (acc_s[63] != acc_a[63])) begin
      acc_sat = acc_a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANES; k++) begin
        sums_q[k] <= '0;
      end
    end else if (retire) begin
      case (prod_i.cmd)
        CMD_ELEM:  sums_q[prod_i.lane] <= acc_sat;
        CMD_CLOSE: begin
          for (int k = 0; k < LANES; k++) begin
            sums_q[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire && (prod_i.cmd == CMD_ROW) && prod_i.ok) begin
      rows_q[prod_i.lane] <= prod_i.row;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (close_retire) begin
      cnt_d = CNT_W'(LANES);
    end else if (out_take) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The emitter is a shift line: lane zero sits at the head.
  always_ff @(posedge clk_i) begin
    if (close_retire) begin
      for (int k = 0; k < LANES; k++) begin
        sh_sum_q[k] <= sums_q[k];
        sh_row_q[k] <= rows_q[k];
      end
    end else if (out_take) begin
      for (int k = 0; k < LANES - 1; k++) begin
        sh_sum_q[k] <= sh_sum_q[k+1];
        sh_row_q[k] <= sh_row_q[k+1];
      end
    end
  end

  assign out_word_o.result_row = sh_row_q[0];
  assign out_word_o.sum        = sh_sum_q[0];
  assign out_word_o.last       = (cnt_q == CNT_W'(1));

  ap_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(LANES))
    else $error("emitter count beyond lane count");

  ap_close_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    close_retire |=> (cnt_q == CNT_W'(LANES)) && (sums_q[0] == '0))
    else $error("close did not load the emitter and clear the sums");

  ap_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && !close_retire) |=> $stable(cnt_q))
    else $error("emitter moved while the receiver stalled");

  ap_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (close_retire && (cnt_q != '0)) |-> (cnt_q == CNT_W'(1)) && out_take)
    else $error("close overwrote a chunk still being emitted");

endmodule

// ===== sv/sell_c_sigma_spmv_top.sv =====
// ----------------------------------------------------------------------------
// sell_c_sigma_spmv_top
// SELL-C-sigma sparse matrix times vector, one chunk of lanes at a time.
// ----------------------------------------------------------------------------
// Input words carry a command: store a Q16.16 vector entry, set the row of a
// lane, feed one matrix value with its column, or close the chunk. Matrix
// values go to consecutive lanes, wrapping at LANES. A close emits LANES
// output words, lane zero first, each with the lane's row and its Q32.32
// saturated sum; the final word has last set.
// The pipeline has three register stages: vector read, multiply, accumulate.
// Store, row and element words are taken one per cycle while in_stall_o is
// low. The first output word of a close is valid once the close has retired
// in the accumulate stage, then one word per cycle while the receiver does
// not stall. A close that reaches the accumulate stage while the previous
// chunk is still being emitted holds the pipeline and raises in_stall_o until
// the emitter drains. The emitter shifts out LANES words per chunk, so the
// input takes one word per cycle only while each close finds it drained.
// Reset clears the lane sums, the lane pointer and the emitter; vector
// entries and lane rows must be written before use. When the receiver
// stalls, the output word holds and the input side keeps accepting words
// until a second close arrives.
// ----------------------------------------------------------------------------
module sell_c_sigma_spmv_top import ssp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ssp_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output ssp_out_t out_word_o
);

  logic      en;
  ssp_prod_t prod;

  ssp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_word_i  (in_word_i),
    .en_i       (en),
    .prod_o     (prod)
  );

  ssp_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prod_i      (prod),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = !en;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SELL-C-sigma sparse matrix times vector block.
// ----------------------------------------------------------------------------
// A directed opening covers the field extremes, the ignored store and row
// words, out-of-range columns and partial and empty chunks. Random chunks
// follow, mixed with noise words. Some chunks use extreme values so that the
// lane sums saturate in both directions. A scoreboard predicts every output
// word from the accepted input words and compares it field by field. Both
// sides idle at changing rates, the receiver once holds off long enough to
// stall the input, and the sender pauses between phases until all is out.
// ----------------------------------------------------------------------------
module tb_top;
  import ssp_pkg::*;

  localparam int LIMIT  = 400000;
  localparam int SETTLE = 4 * LANES + 16;

  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, 63'd0};
  localparam logic [31:0]        VAL_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0]        VAL_MIN = 32'h8000_0000;
  localparam logic [31:0]        VAL_ONE = 32'h0001_0000;

  class spmv_scoreboard;
    logic signed [31:0] vec_mem [VECTOR_DEPTH];
    logic signed [63:0] acc [LANES];
    logic [15:0]        row_of_lane [LANES];
    logic [LANE_W-1:0]  lane_ptr;
    ssp_out_t           sums_due [$];
    int                 errors;
    int                 checked;
    int                 saturated;
    int                 closes;

    function new();
      foreach (vec_mem[i]) vec_mem[i] = '0;
      foreach (acc[i]) acc[i] = '0;
      foreach (row_of_lane[i]) row_of_lane[i] = '0;
      lane_ptr  = '0;
      errors    = 0;
      checked   = 0;
      saturated = 0;
      closes    = 0;
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Updates the predicted state with one accepted input word.
    function void note_input(ssp_in_t w);
      logic signed [63:0] x;
      logic signed [63:0] m;
      logic signed [63:0] prod;
      logic signed [64:0] total;
      ssp_out_t           r;
      case (w.command)
        CMD_STORE: begin
          if (w.index < VECTOR_DEPTH) vec_mem[w.index[VADDR_W-1:0]] = $signed(w.value);
        end
        CMD_ROW: begin
          if (w.index < LANES) row_of_lane[w.index[LANE_W-1:0]] = w.row_number;
        end
        CMD_ELEM: begin
          x = '0;
          if (w.column < VECTOR_DEPTH) x = vec_mem[w.column[VADDR_W-1:0]];
          m = $signed(w.value);
          prod = m * x;
          total = {acc[lane_ptr][63], acc[lane_ptr]} + {prod[63], prod};
          // The two top bits differ only when the 64-bit sum overflowed.
          if (total[64] != total[63]) acc[lane_ptr] = total[64] ? SUM_MIN : SUM_MAX;
          else acc[lane_ptr] = total[63:0];
          lane_ptr = (lane_ptr == LANE_W'(LANES - 1)) ? '0 : lane_ptr + 1'b1;
        end
        CMD_CLOSE: begin
          for (int k = 0; k < LANES; k++) begin
            r.result_row = row_of_lane[k];
            r.sum        = acc[k];
            r.last       = (k == LANES - 1);
            sums_due.push_back(r);
            acc[k] = '0;
          end
          lane_ptr = '0;
          closes++;
        end
        default: ;
      endcase
    endfunction

    task check_result(ssp_out_t got);
      ssp_out_t want;
      if (sums_due.size() == 0) begin
        report($sformatf("unexpected output word row %h sum %h last %b",
                         got.result_row, got.sum, got.last));
        return;
      end
      want = sums_due.pop_front();
      checked++;
      if (want.sum == SUM_MAX || want.sum == SUM_MIN) saturated++;
      if (got.result_row !== want.result_row)
        report($sformatf("row %h, expected %h", got.result_row, want.result_row));
      if (got.sum !== want.sum)
        report($sformatf("sum %h, expected %h (row %h)", got.sum, want.sum,
                         want.result_row));
      if (got.last !== want.last)
        report($sformatf("last %b, expected %b (row %h)", got.last, want.last,
                         want.result_row));
    endtask
  endclass

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ssp_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ssp_out_t out_word;

  spmv_scoreboard sb;
  int  cycles        = 0;
  int  items_sent    = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  hold_len      = 0;
  bit  col_known [VECTOR_DEPTH];
  int  known_cols [$];

  sell_c_sigma_spmv_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #5 clk_i = ~clk_i;

  // The receiver owns its hold-off count; otherwise it stalls at random.
  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni) begin
      if (in_valid && !in_stall) sb.note_input(in_word);
      if (out_valid && !out_stall) sb.check_result(out_word);
    end
    if (cycles > LIMIT) begin
      $display("Timed out after %0d cycles with %0d output words outstanding.",
               cycles, sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  function automatic void mark_known(int idx);
    if (idx < VECTOR_DEPTH && !col_known[idx]) begin
      col_known[idx] = 1'b1;
      known_cols.push_back(idx);
    end
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 9))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return VAL_ONE;
      default: return $urandom;
    endcase
  endfunction

  // Only written vector entries or out-of-range columns are ever picked.
  function automatic int unsigned pick_column();
    if ($urandom_range(0, 9) == 0) return $urandom_range(VECTOR_DEPTH, 65535);
    return known_cols[$urandom_range(0, known_cols.size() - 1)];
  endfunction

  task automatic send(input ssp_cmd_e cmd, input int unsigned idx,
                      input int unsigned row, input logic [31:0] val,
                      input int unsigned col);
    ssp_in_t w;
    w.command    = cmd;
    w.index      = 16'(idx);
    w.row_number = 16'(row);
    w.value      = val;
    w.column     = 16'(col);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  task automatic send_chunk(input bit hot, input int n_elems);
    int n;
    int idx;
    repeat ($urandom_range(0, 2))
      send(CMD_ROW, $urandom_range(0, LANES - 1), $urandom, $urandom, $urandom);
    repeat ($urandom_range(0, 3)) begin
      // These stores skip entries 0 and the top one, which hot chunks read.
      idx = $urandom_range(1, VECTOR_DEPTH - 2);
      mark_known(idx);
      send(CMD_STORE, idx, $urandom, rand_val(), $urandom);
    end
    n = n_elems;
    if (n < 0) n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4 * LANES)
                                               : LANES * $urandom_range(1, 4);
    for (int k = 0; k < n; k++) begin
      if (hot)
        send(CMD_ELEM, $urandom, $urandom, $urandom_range(0, 1) ? VAL_MAX : VAL_MIN,
             $urandom_range(0, 1) ? 0 : VECTOR_DEPTH - 1);
      else
        send(CMD_ELEM, $urandom, $urandom, rand_val(), pick_column());
    end
    send(CMD_CLOSE, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic send_noise();
    ssp_in_t w;
    w.command    = ssp_cmd_e'($urandom_range(0, 3));
    w.index      = $urandom_range(0, 1) ? 16'($urandom)
                                        : 16'($urandom_range(1, VECTOR_DEPTH - 2));
    w.row_number = 16'($urandom);
    w.value      = $urandom;
    w.column     = 16'($urandom);
    if (w.command == CMD_STORE) mark_known(32'(w.index));
    if (w.command == CMD_ELEM && w.column < VECTOR_DEPTH && !col_known[w.column])
      w.column = 16'(pick_column());
    send(w.command, 32'(w.index), 32'(w.row_number), w.value, 32'(w.column));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input int upto);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    while (items_sent < upto) begin
      case ($urandom_range(0, 9))
        0, 1:    repeat ($urandom_range(1, 3)) send_noise();
        2, 3:    send_chunk(1'b1, LANES * $urandom_range(2, 4));
        default: send_chunk(1'b0, -1);
      endcase
    end
    wait_drain();
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every lane row is set first; the ones past the last lane are dropped.
    for (int k = 0; k < LANES; k++)
      send(CMD_ROW, k, (k == 0) ? 32'h0 : (k == LANES - 1) ? 32'hFFFF : $urandom,
           $urandom, $urandom);
    send(CMD_ROW, LANES, $urandom, $urandom, $urandom);
    send(CMD_ROW, 32'hFFFF, $urandom, $urandom, $urandom);

    send(CMD_STORE, 0, $urandom, VAL_MAX, $urandom);
    send(CMD_STORE, VECTOR_DEPTH - 1, $urandom, VAL_MIN, $urandom);
    send(CMD_STORE, 1, $urandom, VAL_ONE, $urandom);
    send(CMD_STORE, VECTOR_DEPTH, $urandom, $urandom, $urandom);
    send(CMD_STORE, 32'hFFFF, $urandom, $urandom, $urandom);
    mark_known(0);
    mark_known(1);
    mark_known(VECTOR_DEPTH - 1);

    // A partial chunk with the largest products and two out-of-range columns,
    // then an empty chunk.
    send(CMD_ELEM, $urandom, $urandom, VAL_MIN, VECTOR_DEPTH - 1);
    send(CMD_ELEM, $urandom, $urandom, VAL_MAX, 0);
    send(CMD_ELEM, $urandom, $urandom, 32'h0001_8000, 1);
    send(CMD_ELEM, $urandom, $urandom, VAL_MAX, 32'hFFFF);
    send(CMD_ELEM, $urandom, $urandom, 32'hFFFF_FFFF, VECTOR_DEPTH);
    send(CMD_CLOSE, $urandom, $urandom, $urandom, $urandom);
    send(CMD_CLOSE, $urandom, $urandom, $urandom, $urandom);
    wait_drain();

    run_phase(36, 85, 140);
    run_phase(85, 36, 260);

    // The receiver holds off while full chunks keep coming, so a second
    // close backs up into the input.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_len = 300;
    repeat (3) send_chunk(1'b0, 2 * LANES);
    wait_drain();

    run_phase(0, 0, 380);

    $display("Covered %0d input words and %0d chunk closes; %0d output words compared.",
             items_sent, sb.closes, sb.checked);
    $display("%0d sums saturated; %0d mismatches.", sb.saturated, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
